// ===== hw/rtl/dpcb_pkg.sv =====
// Display port command bridge: shared codes, reset values and state/result types.
// No dependencies; imported by the interfaces and all modules of the bridge.
package dpcb_pkg;

  // Port write codes
  localparam logic [1:0] CMD_WRITE_COMMAND = 2'd0;
  localparam logic [1:0] CMD_WRITE_DATA    = 2'd1;
  localparam logic [1:0] CMD_BUS_RESET     = 2'd2;

  // Opcodes on the command port
  localparam logic [7:0] OP_SET_SPI      = 8'd0;
  localparam logic [7:0] OP_SET_I2C      = 8'd1;
  localparam logic [7:0] OP_CLEAR_PREFIX = 8'd2;
  localparam logic [7:0] OP_SET_PREFIX   = 8'd3;
  localparam logic [7:0] OP_SET_CLOCK    = 8'd4;
  localparam logic [7:0] OP_SET_MODE     = 8'd5;

  // Result kinds
  localparam logic [1:0] KIND_SPI_WRITE = 2'd0;
  localparam logic [1:0] KIND_I2C_WRITE = 2'd1;
  localparam logic [1:0] KIND_SPI_SETUP = 2'd2;
  localparam logic [1:0] KIND_I2C_SETUP = 2'd3;

  localparam logic [9:0] TIMEOUT_PREFIXED = 10'd1000;
  localparam logic [9:0] TIMEOUT_PLAIN    = 10'd100;

  localparam logic [7:0] CLOCK_RESET = 8'd100;
  localparam logic [1:0] MODE_RESET  = 2'd3;

  typedef struct packed {
    logic       byte_index;
    logic [7:0] pending_opcode;
    logic       spi_selected;
    logic       second_device;
    logic [7:0] target_address;
    logic       prefix_enabled;
    logic [7:0] prefix_value;
    logic [7:0] link_clock;
    logic [1:0] spi_mode_bits;
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       chip_select;
    logic [7:0] bus_address;
    logic [1:0] byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] clock_khz;
    logic [1:0] mode_bits;
    logic [9:0] timeout_us;
  } result_t;

  localparam state_t STATE_RESET = '{
    byte_index:     1'b0,
    pending_opcode: 8'd0,
    spi_selected:   1'b1,
    second_device:  1'b0,
    target_address: 8'd0,
    prefix_enabled: 1'b0,
    prefix_value:   8'd0,
    link_clock:     CLOCK_RESET,
    spi_mode_bits:  MODE_RESET
  };

  function automatic logic takes_parameter(input logic [7:0] op);
    return op inside {OP_SET_SPI, OP_SET_I2C, OP_SET_PREFIX, OP_SET_CLOCK, OP_SET_MODE};
  endfunction

endpackage

// ===== hw/rtl/dpcb_bus_if.sv =====
// Input channel of the bridge: port write code and byte, valid/ready handshake.
// Depends on dpcb_pkg.
interface dpcb_bus_if import dpcb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== hw/rtl/dpcb_result_if.sv =====
// Result channel of the bridge: one SPI/I2C write or link setup descriptor.
// Depends on dpcb_pkg.
interface dpcb_result_if import dpcb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       chip_select;
  logic [7:0] bus_address;
  logic [1:0] byte_count;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] clock_khz;
  logic [1:0] mode_bits;
  logic [9:0] timeout_us;

  modport source (output valid, output kind, output chip_select, output bus_address,
                  output byte_count, output first_byte, output second_byte,
                  output clock_khz, output mode_bits, output timeout_us, input ready);
  modport sink   (input valid, input kind, input chip_select, input bus_address,
                  input byte_count, input first_byte, input second_byte,
                  input clock_khz, input mode_bits, input timeout_us, output ready);
endinterface

// ===== hw/rtl/display_port_command_bridge.sv =====
// Display port command bridge: port writes in, SPI/I2C descriptors out.
// Transactions are staged in an input register, results in the output register.
// Throughput: one transaction per cycle unless the sink stalls; the two registers
// let one more transaction be taken while a result waits on the sink.
// Reset (rst, synchronous): link state returns to its defaults, both registers empty.
// Depends on dpcb_pkg, dpcb_bus_if, dpcb_result_if and dpcb_exec.
module display_port_command_bridge import dpcb_pkg::*; #(
  parameter bit SPI_PRESENT = 1'b1,
  parameter bit I2C_PRESENT = 1'b1
) (
  input logic          clk,
  input logic          rst,
  dpcb_bus_if.sink     bus,
  dpcb_result_if.source result
);

  state_t     state;
  state_t     state_next;
  logic       s_valid;
  logic [1:0] s_command;
  logic [7:0] s_value;
  logic       emit;
  result_t    res_next;
  result_t    res;
  logic       out_valid;
  logic       s_adv;

  dpcb_exec #(
    .SPI_PRESENT(SPI_PRESENT),
    .I2C_PRESENT(I2C_PRESENT)
  ) u_exec (
    .state      (state),
    .command    (s_command),
    .value      (s_value),
    .state_next (state_next),
    .emit       (emit),
    .result     (res_next)
  );

  // the staged transaction retires unless it has a result and the output is stalled
  assign s_adv     = !emit || !out_valid || result.ready;
  assign bus.ready = !s_valid || s_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (bus.ready) s_valid <= bus.valid;
      if (s_valid && s_adv) state <= state_next;
      if (s_valid && s_adv && emit) out_valid <= 1'b1;
      else if (result.ready)        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bus.valid && bus.ready) begin
      s_command <= bus.command;
      s_value   <= bus.value;
    end
    if (s_valid && s_adv && emit) res <= res_next;
  end

  assign result.valid       = out_valid;
  assign result.kind        = res.kind;
  assign result.chip_select = res.chip_select;
  assign result.bus_address = res.bus_address;
  assign result.byte_count  = res.byte_count;
  assign result.first_byte  = res.first_byte;
  assign result.second_byte = res.second_byte;
  assign result.clock_khz   = res.clock_khz;
  assign result.mode_bits   = res.mode_bits;
  assign result.timeout_us  = res.timeout_us;

  a_clock_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.link_clock != 8'd0)
    else $error("link clock reached zero");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !s_adv) |-> (result.valid && !result.ready))
    else $error("staged transaction held without output backpressure");

  a_i2c_timeout: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_I2C_WRITE) |->
      ((result.byte_count == 2'd1 && result.timeout_us == TIMEOUT_PLAIN) ||
       (result.byte_count == 2'd2 && result.timeout_us == TIMEOUT_PREFIXED)))
    else $error("I2C write timeout does not match byte count");

  a_reset_clears_index: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_adv && s_command == CMD_BUS_RESET) |=> !state.byte_index)
    else $error("bus reset left a command pending");

endmodule

// ===== hw/rtl/dpcb_exec.sv =====
// Command/data decode for the bridge: next state and optional result for one transaction.
// Purely combinational; depends on dpcb_pkg.
module dpcb_exec import dpcb_pkg::*; #(
  parameter bit SPI_PRESENT = 1'b1,
  parameter bit I2C_PRESENT = 1'b1
) (
  input  state_t     state,
  input  logic [1:0] command,
  input  logic [7:0] value,
  output state_t     state_next,
  output logic       emit,
  output result_t    result
);

  logic       do_exec;
  logic [7:0] op;
  logic [7:0] param;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    result     = '0;
    result.clock_khz = state.link_clock;
    do_exec    = 1'b0;
    op         = state.pending_opcode;
    param      = value;

    case (command)
      CMD_WRITE_DATA: begin
        // a data byte abandons any half-assembled command
        state_next.byte_index = 1'b0;
        if (SPI_PRESENT && state.spi_selected) begin
          emit               = 1'b1;
          result.kind        = KIND_SPI_WRITE;
          result.chip_select = state.second_device;
          result.byte_count  = 2'd1;
          result.first_byte  = value;
          result.mode_bits   = state.spi_mode_bits;
        end else if (I2C_PRESENT) begin
          emit               = 1'b1;
          result.kind        = KIND_I2C_WRITE;
          result.bus_address = state.target_address;
          if (state.prefix_enabled) begin
            result.byte_count  = 2'd2;
            result.first_byte  = state.prefix_value;
            result.second_byte = value;
            result.timeout_us  = TIMEOUT_PREFIXED;
          end else begin
            result.byte_count  = 2'd1;
            result.first_byte  = value;
            result.timeout_us  = TIMEOUT_PLAIN;
          end
        end
      end
      CMD_BUS_RESET: begin
        state_next.byte_index = 1'b0;
      end
      CMD_WRITE_COMMAND: begin
        if (!state.byte_index) begin
          state_next.pending_opcode = value;
          if (takes_parameter(value)) begin
            state_next.byte_index = 1'b1;
          end else begin
            do_exec = 1'b1;
            op      = value;
            param   = 8'd0;
          end
        end else begin
          state_next.byte_index = 1'b0;
          do_exec = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_exec) begin
      case (op)
        OP_SET_SPI: begin
          state_next.spi_selected  = 1'b1;
          state_next.second_device = (param != 8'd0);
          if (SPI_PRESENT) begin
            emit               = 1'b1;
            result.kind        = KIND_SPI_SETUP;
            result.chip_select = (param != 8'd0);
            result.mode_bits   = state.spi_mode_bits;
          end
        end
        OP_SET_I2C: begin
          state_next.spi_selected   = 1'b0;
          state_next.target_address = param;
          if (I2C_PRESENT) begin
            emit               = 1'b1;
            result.kind        = KIND_I2C_SETUP;
            result.bus_address = param;
          end
        end
        OP_CLEAR_PREFIX: state_next.prefix_enabled = 1'b0;
        OP_SET_PREFIX: begin
          state_next.prefix_enabled = 1'b1;
          state_next.prefix_value   = param;
        end
        OP_SET_CLOCK:  state_next.link_clock = (param == 8'd0) ? 8'd1 : param;
        OP_SET_MODE:   state_next.spi_mode_bits = param[1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
